// ----- rtl/eplu_pkg.sv -----
// Shared types and constants for the exclusion process lattice update block.
// Holds the operation and event codes, the field widths and the occupancy write bundle.
// No dependencies; used by eplu_occ_store and exclusion_process_lattice_update.
package eplu_pkg;

  // Default lattice storage depth and probability resolution.
  localparam int SITES_DEF = 1024;
  localparam int PROB_BITS = 16;

  // Field widths fixed by the stream format.
  localparam int OP_W    = 2;
  localparam int SITE_W  = 10;
  localparam int UNI_W   = 16;
  localparam int PROB_W  = 17;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = 11;
  localparam int EV_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Mask applied to the uniform value so that only PROB_BITS bits take part.
  localparam logic [UNI_W-1:0] UNI_MASK = (PROB_BITS >= UNI_W) ? {UNI_W{1'b1}} :
      UNI_W'((64'd1 << PROB_BITS) - 64'd1);

  // Reset value of the lattice length register.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_RATE   = 2'd1,
    OP_OCC    = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE      = 3'd0,
    EV_ENTRY     = 3'd1,
    EV_EXIT      = 3'd2,
    EV_HOP       = 3'd3,
    EV_ENTRY_HOP = 3'd4
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY  = 2'd0,
    CFG_EXIT   = 2'd1,
    CFG_LENGTH = 2'd2
  } cfg_reg_e;

  // Occupancy write bundle: the addressed site and its right neighbour.
  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic              we_s;
    logic              val_s;
    logic              we_n;
    logic              val_n;
  } occ_wr_t;

endpackage

// ----- rtl/eplu_occ_store.sv -----
// Occupancy store: two one-bit memory banks (even and odd sites) with registered reads.
// Reads a site and its right neighbour together, forwards the write that raced the
// read, and clears the lattice after reset. Depends on eplu_pkg.
module eplu_occ_store #(
  parameter int SITES = eplu_pkg::SITES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [eplu_pkg::SITE_W-1:0]  rd_site_i,
  input  eplu_pkg::occ_wr_t            wr_i,
  output logic                         occ_s_o,
  output logic                         occ_n_o,
  output logic                         busy_o
);

  localparam int ROWS = (SITES + 1) / 2;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW   = eplu_pkg::SITE_W;

  logic           bank_e_mem [ROWS];
  logic           bank_o_mem [ROWS];

  logic [RAW-1:0] rd_row_base, rd_row_plus;
  logic [RAW-1:0] rd_row_e, rd_row_o;
  logic [RAW-1:0] wr_row_base, wr_row_plus;

  logic           we_e, we_o, bit_e, bit_o;
  logic [RAW-1:0] row_e, row_o;
  logic           mwe_e, mwe_o, mbit_e, mbit_o;
  logic [RAW-1:0] mrow_e, mrow_o;

  logic           busy_q, busy_d;
  logic [RAW-1:0] clr_q, clr_d;

  logic           q_e_q, q_o_q;
  logic [RAW-1:0] rrow_e_q, rrow_o_q;
  logic           par_q;
  logic           fwe_e_q, fwe_o_q;
  logic [RAW-1:0] frow_e_q, frow_o_q;
  logic           fbit_e_q, fbit_o_q;
  logic           eff_e, eff_o;

  // Row addresses: an odd site finds its neighbour in the next even row.
  assign rd_row_base = RAW'(rd_site_i[SW-1:1]);
  assign rd_row_plus = RAW'({1'b0, rd_site_i[SW-1:1]} + SW'(1));
  assign rd_row_e    = rd_site_i[0] ? rd_row_plus : rd_row_base;
  assign rd_row_o    = rd_row_base;

  assign wr_row_base = RAW'(wr_i.site[SW-1:1]);
  assign wr_row_plus = RAW'({1'b0, wr_i.site[SW-1:1]} + SW'(1));

  // Steer the two site writes onto the banks by parity.
  always_comb begin
    we_e  = wr_i.site[0] ? wr_i.we_n  : wr_i.we_s;
    bit_e = wr_i.site[0] ? wr_i.val_n : wr_i.val_s;
    row_e = wr_i.site[0] ? wr_row_plus : wr_row_base;
    we_o  = wr_i.site[0] ? wr_i.we_s  : wr_i.we_n;
    bit_o = wr_i.site[0] ? wr_i.val_s : wr_i.val_n;
    row_o = wr_row_base;
  end

  // The clearing pass owns the write ports while it runs.
  always_comb begin
    mwe_e  = busy_q | we_e;
    mwe_o  = busy_q | we_o;
    mbit_e = busy_q ? 1'b0 : bit_e;
    mbit_o = busy_q ? 1'b0 : bit_o;
    mrow_e = busy_q ? clr_q : row_e;
    mrow_o = busy_q ? clr_q : row_o;
  end

  // Clearing pass sequencing: one row of both banks per cycle.
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      if (clr_q == RAW'(ROWS - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + RAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      clr_q   <= '0;
      fwe_e_q <= 1'b0;
      fwe_o_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
      if (rd_en_i) begin
        fwe_e_q <= we_e;
        fwe_o_q <= we_o;
      end
    end
  end

  // Record of the write that landed at the same edge as the read, for forwarding.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      frow_e_q <= row_e;
      frow_o_q <= row_o;
      fbit_e_q <= bit_e;
      fbit_o_q <= bit_o;
      rrow_e_q <= rd_row_e;
      rrow_o_q <= rd_row_o;
      par_q    <= rd_site_i[0];
    end
  end

  // Even bank.
  always_ff @(posedge clk_i) begin
    if (mwe_e) begin
      bank_e_mem[mrow_e] <= mbit_e;
    end
    if (rd_en_i) begin
      q_e_q <= bank_e_mem[rd_row_e];
    end
  end

  // Odd bank.
  always_ff @(posedge clk_i) begin
    if (mwe_o) begin
      bank_o_mem[mrow_o] <= mbit_o;
    end
    if (rd_en_i) begin
      q_o_q <= bank_o_mem[rd_row_o];
    end
  end

  // Forwarded read data, then back from banks to site and neighbour.
  assign eff_e = (fwe_e_q && (frow_e_q == rrow_e_q)) ? fbit_e_q : q_e_q;
  assign eff_o = (fwe_o_q && (frow_o_q == rrow_o_q)) ? fbit_o_q : q_o_q;

  assign occ_s_o = par_q ? eff_o : eff_e;
  assign occ_n_o = par_q ? eff_e : eff_o;
  assign busy_o  = busy_q;

endmodule

// ----- rtl/exclusion_process_lattice_update.sv -----
// Exclusion process lattice update: one-way particle lattice with per-site hop rates.
// Top level with the stream ports, configuration registers, hop rate memory and result
// register. Depends on eplu_pkg and eplu_occ_store.
//
//  Channel  Direction  Beat contents (lowest bits first)
//  s_axis   in         tuser: operation; tdata: site, uniform, rate_value, occupancy_value
//  m_axis   out        tdata: event_res, site_out, occupied_after, particle_count
//  cfg      in         cfg_we_i, cfg_idx_i (register index), cfg_wdata_i
//
// One item is accepted per cycle while s_axis_tready is high; it waits in stage one for its
// memory reads and then moves to the result register. Occupancy comes from the occupancy banks,
// read once per beat for a site and its right neighbour, with the previous beat's write
// forwarded; the hop rate comes from the rate memory. A clearing pass after reset empties the
// lattice row by row; no beat is accepted during it. A stalled output holds the result register
// and the item behind it, and s_axis_tready falls while both are full.
module exclusion_process_lattice_update #(
  parameter int SITES = eplu_pkg::SITES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Update stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // site, uniform, rate_value, occupancy_value
  input  logic [eplu_pkg::OP_W-1:0]      s_axis_tuser,  // operation
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,  // event_res, site_out, occupied_after, particle_count
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [eplu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [eplu_pkg::PROB_W-1:0]    cfg_wdata_i
);

  localparam int SW  = eplu_pkg::SITE_W;
  localparam int PW  = eplu_pkg::PROB_W;
  localparam int UW  = eplu_pkg::UNI_W;
  localparam int HAW = $clog2(SITES);
  localparam int PCW = $clog2(SITES + 1);
  localparam int LW  = (PCW > eplu_pkg::LEN_W) ? PCW : eplu_pkg::LEN_W;

  // Input beat fields.
  logic [SW-1:0]  in_site;
  logic [UW-1:0]  in_uni;
  logic [PW-1:0]  in_rate;
  logic           in_occ;
  logic           in_accept;

  assign in_site = s_axis_tdata[9:0];
  assign in_uni  = s_axis_tdata[25:10];
  assign in_rate = s_axis_tdata[42:26];
  assign in_occ  = s_axis_tdata[43];

  // Configuration registers.
  logic [PW-1:0]              entry_q, exit_q;
  logic [eplu_pkg::LEN_W-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      exit_q  <= '0;
      len_q   <= eplu_pkg::LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        eplu_pkg::CFG_ENTRY:  entry_q <= cfg_wdata_i;
        eplu_pkg::CFG_EXIT:   exit_q  <= cfg_wdata_i;
        eplu_pkg::CFG_LENGTH: len_q   <= cfg_wdata_i[eplu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one holds the item whose memory reads are under way.
  logic                s1_valid_q;
  eplu_pkg::op_e       s1_op_q;
  logic [SW-1:0]       s1_site_q;
  logic [UW-1:0]       s1_uni_q;
  logic [PW-1:0]       s1_rate_q;
  logic                s1_occ_q;
  logic                s1_fire;

  // Result register.
  logic                out_valid_q;
  eplu_pkg::event_e    out_ev_q;
  logic [SW-1:0]       out_site_q;
  logic                out_occ_q;
  logic [PCW-1:0]      pop_q, pop_d;

  logic                busy;
  logic                occ_s, occ_n;
  eplu_pkg::occ_wr_t   occ_wr;

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy && (!s1_valid_q || s1_fire);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pop_q       <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        pop_q       <= pop_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q   <= eplu_pkg::op_e'(s_axis_tuser);
      s1_site_q <= in_site;
      s1_uni_q  <= in_uni;
      s1_rate_q <= in_rate;
      s1_occ_q  <= in_occ;
    end
  end

  // Hop rate memory, with the write that raced the read forwarded.
  logic [PW-1:0]  rate_mem [SITES];
  logic [PW-1:0]  rate_rd_q;
  logic           rate_we;
  logic [HAW-1:0] rate_idx;
  logic           rfwd_we_q;
  logic [HAW-1:0] rfwd_idx_q;
  logic [PW-1:0]  rfwd_val_q;
  logic [PW-1:0]  rate_eff;
  logic           in_store;

  assign rate_idx = HAW'(s1_site_q);
  assign rate_we  = s1_fire && (s1_op_q == eplu_pkg::OP_RATE) && in_store;

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      rate_mem[rate_idx] <= s1_rate_q;
    end
    if (in_accept) begin
      rate_rd_q  <= rate_mem[HAW'(in_site)];
      rfwd_idx_q <= rate_idx;
      rfwd_val_q <= s1_rate_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rfwd_we_q <= 1'b0;
    end else if (in_accept) begin
      rfwd_we_q <= rate_we;
    end
  end

  assign rate_eff = (rfwd_we_q && (rfwd_idx_q == rate_idx)) ? rfwd_val_q : rate_rd_q;

  // Occupancy banks.
  eplu_occ_store #(
    .SITES (SITES)
  ) u_occ_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_site_i (in_site),
    .wr_i      (occ_wr),
    .occ_s_o   (occ_s),
    .occ_n_o   (occ_n),
    .busy_o    (busy)
  );

  // Update decision for the item in stage one.
  logic [LW-1:0]    site_ext, len_ext, len_use;
  logic             in_len, at_last, at_first;
  logic [PW-1:0]    uni_cmp;
  logic             entered, mid;
  logic             new_s, new_n, we_s, we_n;
  eplu_pkg::event_e ev;

  always_comb begin
    site_ext = LW'(s1_site_q);
    len_ext  = LW'(len_q);
    if (len_ext < LW'(2)) begin
      len_use = LW'(2);
    end else if (len_ext > LW'(SITES)) begin
      len_use = LW'(SITES);
    end else begin
      len_use = len_ext;
    end
    in_store = site_ext < LW'(SITES);
    in_len   = site_ext < len_use;
    at_last  = site_ext == (len_use - LW'(1));
    at_first = s1_site_q == '0;
    uni_cmp  = PW'(s1_uni_q & eplu_pkg::UNI_MASK);

    entered = 1'b0;
    mid     = occ_s;
    new_s   = occ_s;
    new_n   = occ_n;
    we_s    = 1'b0;
    we_n    = 1'b0;
    ev      = eplu_pkg::EV_NONE;

    case (s1_op_q)
      eplu_pkg::OP_UPDATE: begin
        if (in_len) begin
          entered = at_first && !occ_s && (uni_cmp < entry_q);
          mid     = occ_s | entered;
          we_s    = 1'b1;
          new_s   = mid;
          ev      = entered ? eplu_pkg::EV_ENTRY : eplu_pkg::EV_NONE;
          if (at_last) begin
            if (mid && (uni_cmp < exit_q)) begin
              new_s = 1'b0;
              ev    = eplu_pkg::EV_EXIT;
            end
          end else if (mid && !occ_n && (uni_cmp < rate_eff)) begin
            new_s = 1'b0;
            new_n = 1'b1;
            we_n  = 1'b1;
            ev    = entered ? eplu_pkg::EV_ENTRY_HOP : eplu_pkg::EV_HOP;
          end
        end
      end
      eplu_pkg::OP_OCC: begin
        if (in_store) begin
          we_s  = 1'b1;
          new_s = s1_occ_q;
        end
      end
      default: ;
    endcase

    // Only written sites enter the particle count.
    pop_d = pop_q + PCW'(we_s & new_s) + PCW'(we_n & new_n)
                  - PCW'(we_s & occ_s) - PCW'(we_n & occ_n);

    occ_wr.site  = s1_site_q;
    occ_wr.we_s  = s1_fire && we_s;
    occ_wr.val_s = new_s;
    occ_wr.we_n  = s1_fire && we_n;
    occ_wr.val_n = new_n;
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_ev_q   <= ev;
      out_site_q <= s1_site_q;
      out_occ_q  <= in_store && new_s;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, eplu_pkg::CNT_W'(pop_q), out_occ_q, out_site_q, out_ev_q};

`ifndef ASSERT_OFF
  // The particle count never exceeds the number of stored sites.
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(pop_q) <= LW'(SITES))
    else $error("particle count above lattice size");

  // No beat is taken while the clearing pass runs.
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready && !s1_valid_q)
    else $error("item accepted during clearing pass");

  // A plain hop or an exit leaves the addressed site empty.
  a_hop_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_ev_q == eplu_pkg::EV_HOP || out_ev_q == eplu_pkg::EV_EXIT)
      |-> !out_occ_q)
    else $error("site still occupied after hop or exit");

  // A particle count change needs an item leaving stage one.
  a_pop_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(pop_q))
    else $error("particle count changed without an item");
`endif

endmodule
